### src/page_framebuffer_line_drawer_unit_assert.svh
// assertion helpers, clocked on i_clk, disabled in reset
`ifndef PAGE_FRAMEBUFFER_LINE_DRAWER_UNIT_ASSERT_SVH
`define PAGE_FRAMEBUFFER_LINE_DRAWER_UNIT_ASSERT_SVH

// consequent in the same cycle
`define PFLD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent in the next cycle
`define PFLD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/pfld_pkg.sv
package pfld_pkg;

    localparam int PAGE_ROWS = 8;
    localparam logic [7:0] BYTE_MASK = 8'hFF;

    typedef enum logic [1:0] {
        OP_PLOT  = 2'd0,
        OP_LINE  = 2'd1,
        OP_READ  = 2'd2,
        OP_CLEAR = 2'd3
    } t_op;

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_LINE  = 5'b00100,
        S_READ  = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    typedef struct packed {
        logic load;
        logic clr_init;
        logic clr_step;
        logic pix_issue;
        logic rd_issue;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic at_end;
        logic clr_last;
        logic out_free;
    } t_dp_stat;

endpackage

### src/pfld_if.sv
interface pfld_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] operation;
    logic [7:0] start_x;
    logic [7:0] start_y;
    logic [7:0] end_x;
    logic [7:0] end_y;
    logic       color;
    logic [8:0] byte_index;

    modport source (
        output valid, operation, start_x, start_y, end_x, end_y, color, byte_index,
        input  ready
    );
    modport sink (
        input  valid, operation, start_x, start_y, end_x, end_y, color, byte_index,
        output ready
    );
endinterface

interface pfld_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;

    modport source (output valid, read_data, input ready);
    modport sink (input valid, read_data, output ready);
endinterface

### src/pfld_ram.sv
module pfld_ram #(
    parameter int W     = 8,
    parameter int DEPTH = 512,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);

    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### src/pfld_ctrl.sv
module pfld_ctrl
    import pfld_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [1:0] i_op,
    output logic       o_ready,
    input  t_dp_stat   i_stat,
    output t_dp_cmd    o_cmd
);

    t_state r_state, n_state;
    logic   r_clr_resp, n_clr_resp;

    always_comb begin
        n_state    = r_state;
        n_clr_resp = r_clr_resp;
        o_cmd      = '0;
        o_ready    = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = r_clr_resp ? S_DONE : S_IDLE;
                end
            end
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    case (t_op'(i_op))
                        OP_PLOT, OP_LINE: n_state = S_LINE;
                        OP_READ:          n_state = S_READ;
                        default: begin
                            o_cmd.clr_init = 1'b1;
                            n_clr_resp     = 1'b1;
                            n_state        = S_CLEAR;
                        end
                    endcase
                end
            end
            S_LINE: begin
                o_cmd.pix_issue = 1'b1;
                if (i_stat.at_end) begin
                    n_state = S_DONE;
                end
            end
            S_READ: begin
                o_cmd.rd_issue = 1'b1;
                n_state        = S_DONE;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_resp <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_resp <= n_clr_resp;
        end
    end

endmodule

### src/pfld_datapath.sv
module pfld_datapath
    import pfld_pkg::*;
#(
    parameter int WIDTH  = 128,
    parameter int HEIGHT = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_dp_cmd    i_cmd,
    output t_dp_stat   o_stat,
    input  logic [1:0] i_operation,
    input  logic [7:0] i_start_x,
    input  logic [7:0] i_start_y,
    input  logic [7:0] i_end_x,
    input  logic [7:0] i_end_y,
    input  logic       i_color,
    input  logic [8:0] i_byte_index,
    input  logic       i_out_ready,
    output logic       o_out_valid,
    output logic [7:0] o_read_data
);

    localparam int PAGES       = (HEIGHT + PAGE_ROWS - 1) / PAGE_ROWS;
    localparam int STORE_BYTES = WIDTH * PAGES;
    localparam int AW          = $clog2(STORE_BYTES);

    // line walker
    logic [7:0]         r_x, r_y, r_ex, r_ey, r_dx, r_dy;
    logic               r_sx, r_sy, r_color;
    logic signed [10:0] r_err;
    // request latched at load
    logic               r_is_read, r_rd_ok;
    logic [AW-1:0]      r_bi_addr;
    // write-back stage and forward path
    logic               r_s2_valid, r_fw_valid;
    logic [AW-1:0]      r_s2_addr, r_fw_addr;
    logic [2:0]         r_s2_bit;
    logic               r_s2_color;
    logic [7:0]         r_fw_data;
    // clearing sweep
    logic [AW-1:0]      r_clr_cnt;
    // result register
    logic               r_out_valid;
    logic [7:0]         r_out_data;

    logic [7:0]         w_ld_ex, w_ld_ey, w_ld_dx, w_ld_dy;
    logic signed [11:0] w_e2, w_ndy, w_dx12;
    logic               w_step_x, w_step_y;
    logic signed [10:0] w_err_next;
    logic [15:0]        w_addr_full;
    logic [AW-1:0]      w_pix_addr;
    logic               w_on_screen;
    logic [7:0]         w_base, w_mask, w_new;
    logic               w_we, w_re;
    logic [AW-1:0]      w_waddr, w_raddr;
    logic [7:0]         w_wdata, w_rdata;
    logic               w_out_free;

    always_comb begin
        w_ld_ex = (i_operation == OP_PLOT) ? i_start_x : i_end_x;
        w_ld_ey = (i_operation == OP_PLOT) ? i_start_y : i_end_y;
        w_ld_dx = (w_ld_ex >= i_start_x) ? w_ld_ex - i_start_x : i_start_x - w_ld_ex;
        w_ld_dy = (w_ld_ey >= i_start_y) ? w_ld_ey - i_start_y : i_start_y - w_ld_ey;

        w_e2       = $signed({r_err, 1'b0});
        w_ndy      = -$signed({4'b0, r_dy});
        w_dx12     = $signed({4'b0, r_dx});
        w_step_x   = w_e2 > w_ndy;
        w_step_y   = w_e2 < w_dx12;
        w_err_next = r_err - (w_step_x ? $signed({3'b0, r_dy}) : 11'sd0)
                           + (w_step_y ? $signed({3'b0, r_dx}) : 11'sd0);

        w_addr_full = 16'(r_x) + 16'(r_y / PAGE_ROWS) * 16'(WIDTH);
        w_pix_addr  = w_addr_full[AW-1:0];
        w_on_screen = ({1'b0, r_x} < 9'(WIDTH)) && ({1'b0, r_y} < 9'(HEIGHT));

        w_base = (r_fw_valid && (r_fw_addr == r_s2_addr)) ? r_fw_data : w_rdata;
        w_mask = 8'(1) << r_s2_bit;
        w_new  = r_s2_color ? (w_base | w_mask) : (w_base & (BYTE_MASK ^ w_mask));

        w_we    = r_s2_valid || i_cmd.clr_step;
        w_waddr = i_cmd.clr_step ? r_clr_cnt : r_s2_addr;
        w_wdata = i_cmd.clr_step ? 8'h00 : w_new;
        w_re    = i_cmd.pix_issue || i_cmd.rd_issue;
        w_raddr = i_cmd.rd_issue ? r_bi_addr : w_pix_addr;

        w_out_free = !r_out_valid || i_out_ready;
    end

    pfld_ram #(
        .W     (8),
        .DEPTH (STORE_BYTES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x       <= i_start_x;
            r_y       <= i_start_y;
            r_ex      <= w_ld_ex;
            r_ey      <= w_ld_ey;
            r_dx      <= w_ld_dx;
            r_dy      <= w_ld_dy;
            r_sx      <= i_start_x < w_ld_ex;
            r_sy      <= i_start_y < w_ld_ey;
            r_err     <= $signed({3'b0, w_ld_dx}) - $signed({3'b0, w_ld_dy});
            r_color   <= i_color;
            r_is_read <= i_operation == OP_READ;
            r_rd_ok   <= 32'(i_byte_index) < STORE_BYTES;
            r_bi_addr <= AW'(i_byte_index);
        end else if (i_cmd.pix_issue) begin
            r_err <= w_err_next;
            if (w_step_x) begin
                r_x <= r_sx ? r_x + 8'd1 : r_x - 8'd1;
            end
            if (w_step_y) begin
                r_y <= r_sy ? r_y + 8'd1 : r_y - 8'd1;
            end
        end
        r_s2_addr  <= w_pix_addr;
        r_s2_bit   <= 3'(r_y % PAGE_ROWS);
        r_s2_color <= r_color;
        r_fw_addr  <= r_s2_addr;
        r_fw_data  <= w_new;
        if (i_cmd.out_load) begin
            r_out_data <= (r_is_read && r_rd_ok) ? w_rdata : 8'h00;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid  <= 1'b0;
            r_fw_valid  <= 1'b0;
            r_clr_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_s2_valid <= i_cmd.pix_issue && w_on_screen;
            r_fw_valid <= r_s2_valid;
            if (i_cmd.clr_init) begin
                r_clr_cnt <= '0;
            end else if (i_cmd.clr_step) begin
                r_clr_cnt <= r_clr_cnt + AW'(1);
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stat.at_end   = (r_x == r_ex) && (r_y == r_ey);
    assign o_stat.clr_last = r_clr_cnt == AW'(STORE_BYTES - 1);
    assign o_stat.out_free = w_out_free;
    assign o_out_valid     = r_out_valid;
    assign o_read_data     = r_out_data;

endmodule

### src/page_framebuffer_line_drawer_unit.sv
// page-organized monochrome framebuffer with a line drawer
// i_cmd carries one request: plot pixel, draw line, read byte or clear store.
// o_rsp returns exactly one byte per request: the stored byte for a read,
// zero otherwise. pixel (x, y) lives in byte x + (y / 8) * WIDTH, bit y mod 8.
// a request is taken only while the engine is idle; one at a time.
// steps from acceptance to result valid:
//   plot pixel  one store read-modify-write of the pixel's byte
//   draw line   one store read-modify-write per pixel,
//               back-to-back through a write-back stage with byte forwarding
//   read byte   one store read, its byte loaded into the output register
//   clear store every byte set to zero, one byte per cycle
// the next request can be taken in the cycle its predecessor's result
// goes valid. after reset the store is swept to zero before the first
// request is taken.
// a result waits in an output register while o_rsp.ready is low; the next
// request is still taken, and its result is held back until the slot frees.
`include "page_framebuffer_line_drawer_unit_assert.svh"

module page_framebuffer_line_drawer_unit
    import pfld_pkg::*;
#(
    parameter int WIDTH  = 128,
    parameter int HEIGHT = 32
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    pfld_cmd_if.sink        i_cmd,
    pfld_rsp_if.source      o_rsp
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    pfld_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_cmd.valid),
        .i_op    (i_cmd.operation),
        .o_ready (i_cmd.ready),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    pfld_datapath #(
        .WIDTH  (WIDTH),
        .HEIGHT (HEIGHT)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .i_operation  (i_cmd.operation),
        .i_start_x    (i_cmd.start_x),
        .i_start_y    (i_cmd.start_y),
        .i_end_x      (i_cmd.end_x),
        .i_end_y      (i_cmd.end_y),
        .i_color      (i_cmd.color),
        .i_byte_index (i_cmd.byte_index),
        .i_out_ready  (o_rsp.ready),
        .o_out_valid  (o_rsp.valid),
        .o_read_data  (o_rsp.read_data)
    );

    `PFLD_ASSERT_NOW(a_cmd_exclusive, 1'b1, $onehot0({w_cmd.load, w_cmd.clr_step, w_cmd.pix_issue, w_cmd.rd_issue, w_cmd.out_load}), "datapath commands overlap")
    `PFLD_ASSERT_NOW(a_no_overwrite, w_cmd.out_load, w_stat.out_free, "result loaded over a pending one")
    `PFLD_ASSERT_NEXT(a_one_at_a_time, i_cmd.valid && i_cmd.ready, !i_cmd.ready, "request taken while busy")

endmodule

### bench/page_framebuffer_checker.sv
module page_framebuffer_checker
    import pfld_pkg::*;
#(
    parameter int WIDTH  = 128,
    parameter int HEIGHT = 32
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    pfld_cmd_if   i_cmd,
    pfld_rsp_if   i_rsp,
    output int    o_fail_count,
    output int    o_pending
);

    localparam int PAGES       = (HEIGHT + PAGE_ROWS - 1) / PAGE_ROWS;
    localparam int STORE_BYTES = WIDTH * PAGES;

    logic [7:0] frame_bytes [STORE_BYTES];
    logic [7:0] expected_bytes [$];
    int         mismatches;

    function automatic void paint_pixel(int x, int y, logic color);
        int         idx;
        logic [7:0] mask;
        if (x < WIDTH && y < HEIGHT) begin
            idx  = x + (y / PAGE_ROWS) * WIDTH;
            mask = 8'(1 << (y % PAGE_ROWS));
            if (color) begin
                frame_bytes[idx] = frame_bytes[idx] | mask;
            end else begin
                frame_bytes[idx] = frame_bytes[idx] & (BYTE_MASK ^ mask);
            end
        end
    endfunction

    // integer error walk, each coordinate stepping toward its end modulo 256
    function automatic void trace_line(int x0, int y0, int x1, int y1, logic color);
        int dx;
        int dy;
        int step_x;
        int step_y;
        int err;
        int e2;
        int x;
        int y;
        dx     = (x1 >= x0) ? x1 - x0 : x0 - x1;
        dy     = (y1 >= y0) ? y1 - y0 : y0 - y1;
        step_x = (x0 < x1) ? 1 : 255;
        step_y = (y0 < y1) ? 1 : 255;
        err    = dx - dy;
        x      = x0;
        y      = y0;
        for (int n = 0; n < 1024; n++) begin
            paint_pixel(x, y, color);
            if (x == x1 && y == y1) break;
            e2 = err + err;
            if (e2 > -dy) begin
                err -= dy;
                x = (x + step_x) & 255;
            end
            if (e2 < dx) begin
                err += dx;
                y = (y + step_y) & 255;
            end
        end
    endfunction

    function automatic void wipe_store();
        foreach (frame_bytes[i]) frame_bytes[i] = '0;
    endfunction

    initial begin
        mismatches = 0;
        wipe_store();
    end

    always @(posedge i_clk) begin
        logic [7:0] want;
        if (!i_rst_n) begin
            wipe_store();
            expected_bytes.delete();
        end else begin
            if (i_cmd.valid && i_cmd.ready) begin
                want = '0;
                case (t_op'(i_cmd.operation))
                    OP_PLOT: begin
                        paint_pixel(i_cmd.start_x, i_cmd.start_y, i_cmd.color);
                    end
                    OP_LINE: begin
                        trace_line(i_cmd.start_x, i_cmd.start_y, i_cmd.end_x, i_cmd.end_y,
                                   i_cmd.color);
                    end
                    OP_READ: begin
                        if (int'(i_cmd.byte_index) < STORE_BYTES) begin
                            want = frame_bytes[i_cmd.byte_index];
                        end
                    end
                    default: begin
                        wipe_store();
                    end
                endcase
                expected_bytes.push_back(want);
            end
            if (i_rsp.valid && i_rsp.ready) begin
                if (expected_bytes.size() == 0) begin
                    $error("read_data: no request outstanding, got %02h", i_rsp.read_data);
                    mismatches++;
                end else begin
                    want = expected_bytes.pop_front();
                    if (i_rsp.read_data !== want) begin
                        $error("read_data: expected %02h, got %02h", want, i_rsp.read_data);
                        mismatches++;
                    end
                end
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= expected_bytes.size();
    end

endmodule

### bench/tb.sv
module tb;
    import pfld_pkg::*;

    localparam int WIDTH          = 128;
    localparam int HEIGHT         = 32;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_CYCLES    = 300;
    localparam int PHASE_ITEMS    = 210;

    logic i_clk = 1'b0;
    logic i_rst_n;

    int fail_count;
    int pending;
    int tx_idle_pct;
    int rx_idle_pct;
    logic hold_request;
    int quiet_cycles;
    int op_counts [4];

    pfld_cmd_if cmd_bus ();
    pfld_rsp_if rsp_bus ();

    page_framebuffer_line_drawer_unit #(
        .WIDTH  (WIDTH),
        .HEIGHT (HEIGHT)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_bus),
        .o_rsp   (rsp_bus)
    );

    page_framebuffer_checker #(
        .WIDTH  (WIDTH),
        .HEIGHT (HEIGHT)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd_bus),
        .i_rsp        (rsp_bus),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #5 i_clk = ~i_clk;

    // response side: random backpressure plus one long hold-off
    initial begin
        bit held;
        held = 1'b0;
        rsp_bus.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request && !held) begin
                held = 1'b1;
                rsp_bus.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                rsp_bus.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((cmd_bus.valid && cmd_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_request(t_op op, logic [7:0] sx, logic [7:0] sy,
                                logic [7:0] ex, logic [7:0] ey, logic color,
                                logic [8:0] bi);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            cmd_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        cmd_bus.valid      <= 1'b1;
        cmd_bus.operation  <= op;
        cmd_bus.start_x    <= sx;
        cmd_bus.start_y    <= sy;
        cmd_bus.end_x      <= ex;
        cmd_bus.end_y      <= ey;
        cmd_bus.color      <= color;
        cmd_bus.byte_index <= bi;
        @(posedge i_clk);
        while (!cmd_bus.ready) @(posedge i_clk);
        op_counts[op]++;
    endtask

    // mostly near the visible area, sometimes anywhere in the 8-bit range
    function automatic logic [7:0] pick_coord(int span);
        if ($urandom_range(0, 3) == 0) begin
            return 8'($urandom_range(0, 255));
        end
        return 8'($urandom_range(0, span + 7));
    endfunction

    task automatic send_random();
        int   pick;
        t_op  op;
        pick = $urandom_range(0, 99);
        if (pick < 25) begin
            op = OP_PLOT;
        end else if (pick < 60) begin
            op = OP_LINE;
        end else if (pick < 98) begin
            op = OP_READ;
        end else begin
            op = OP_CLEAR;
        end
        send_request(op, pick_coord(WIDTH), pick_coord(HEIGHT), pick_coord(WIDTH),
                     pick_coord(HEIGHT), 1'($urandom_range(0, 1)),
                     9'($urandom_range(0, 511)));
    endtask

    initial begin
        cmd_bus.valid      = 1'b0;
        cmd_bus.operation  = OP_PLOT;
        cmd_bus.start_x    = '0;
        cmd_bus.start_y    = '0;
        cmd_bus.end_x      = '0;
        cmd_bus.end_y      = '0;
        cmd_bus.color      = 1'b0;
        cmd_bus.byte_index = '0;
        i_rst_n            = 1'b0;
        quiet_cycles       = 0;
        hold_request       = 1'b0;
        tx_idle_pct        = 16;
        rx_idle_pct        = 81;
        foreach (op_counts[i]) op_counts[i] = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // corners, off-screen pixels, line shapes, reads, clear
        send_request(OP_PLOT, 8'd0, 8'd0, 8'd77, 8'd200, 1'b1, 9'd300);
        send_request(OP_PLOT, 8'd127, 8'd31, 8'd255, 8'd0, 1'b1, 9'd511);
        send_request(OP_PLOT, 8'd128, 8'd0, 8'd0, 8'd0, 1'b1, 9'd0);
        send_request(OP_PLOT, 8'd0, 8'd32, 8'd0, 8'd0, 1'b1, 9'd0);
        send_request(OP_PLOT, 8'd255, 8'd255, 8'd255, 8'd255, 1'b1, 9'd511);
        send_request(OP_READ, 8'd255, 8'd255, 8'd255, 8'd255, 1'b1, 9'd0);
        send_request(OP_READ, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 9'd511);
        send_request(OP_LINE, 8'd0, 8'd8, 8'd127, 8'd8, 1'b1, 9'd0);
        send_request(OP_LINE, 8'd5, 8'd0, 8'd5, 8'd31, 1'b1, 9'd0);
        send_request(OP_LINE, 8'd120, 8'd31, 8'd0, 8'd0, 1'b1, 9'd0);
        send_request(OP_LINE, 8'd200, 8'd250, 8'd10, 8'd3, 1'b1, 9'd0);
        send_request(OP_LINE, 8'd255, 8'd0, 8'd0, 8'd255, 1'b1, 9'd0);
        send_request(OP_LINE, 8'd40, 8'd20, 8'd40, 8'd20, 1'b1, 9'd0);
        send_request(OP_LINE, 8'd0, 8'd8, 8'd127, 8'd8, 1'b0, 9'd0);
        send_request(OP_PLOT, 8'd5, 8'd10, 8'd0, 8'd0, 1'b0, 9'd0);
        send_request(OP_READ, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 9'd133);
        send_request(OP_READ, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 9'd192);
        send_request(OP_READ, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 9'd384);
        send_request(OP_CLEAR, 8'd170, 8'd85, 8'd170, 8'd85, 1'b1, 9'd341);
        send_request(OP_READ, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 9'd133);
        send_request(OP_LINE, 8'd0, 8'd0, 8'd255, 8'd255, 1'b1, 9'd0);
        send_request(OP_READ, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 9'd0);
        send_request(OP_READ, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 9'd387);

        repeat (PHASE_ITEMS) send_random();

        tx_idle_pct <= 81;
        rx_idle_pct <= 16;
        repeat (PHASE_ITEMS) send_random();

        // no idling; responses held off early so requests back up
        tx_idle_pct  <= 0;
        rx_idle_pct  <= 0;
        hold_request <= 1'b1;
        repeat (PHASE_ITEMS) send_random();

        cmd_bus.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (300) @(posedge i_clk);

        $display("covered %0d plot, %0d line, %0d read and %0d clear requests",
                 op_counts[OP_PLOT], op_counts[OP_LINE], op_counts[OP_READ],
                 op_counts[OP_CLEAR]);
        $display("with idling on either side and a %0d-cycle response hold-off",
                 HOLD_CYCLES);
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
